FILE: rtl/mcmq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcmq_pkg;

  // physical button state code carried by each frame word
  typedef enum logic [1:0] {
    BTN_UP       = 2'd0,
    BTN_PRESS    = 2'd1,
    BTN_HELD     = 2'd2,
    BTN_RELEASED = 2'd3
  } btn_state_t;

  // configuration register index (byte address / 4)
  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_DCLICK_WINDOW = 2'd2,
    REG_LEFT_HANDED   = 2'd3
  } reg_idx_t;

  // event bit positions within a button's event field
  localparam int unsigned EV_DOWN   = 0;
  localparam int unsigned EV_UP     = 1;
  localparam int unsigned EV_DOUBLE = 2;

  // button indexes (physical and logical share numbering)
  localparam int unsigned BTN_LEFT   = 0;
  localparam int unsigned BTN_RIGHT  = 1;
  localparam int unsigned BTN_MIDDLE = 2;
  localparam int unsigned NUM_BTNS   = 3;

  localparam int unsigned SIZE_BITS   = 13;
  localparam int unsigned WINDOW_BITS = 16;
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned RAW_BITS    = 16;
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;

  localparam logic [SIZE_BITS-1:0]   RST_SCREEN_WIDTH  = 13'd800;
  localparam logic [SIZE_BITS-1:0]   RST_SCREEN_HEIGHT = 13'd600;
  localparam logic [WINDOW_BITS-1:0] RST_DCLICK_WINDOW = 16'd500;

  typedef logic [2:0] btn_ev_t;

endpackage

`default_nettype wire

FILE: rtl/mcmq_if.sv
`timescale 1ns / 1ps
`default_nettype none

// frame word channel
interface mcmq_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  raw_x;
  logic signed [15:0]  raw_y;
  logic        [31:0]  now_ms;
  logic        [1:0]   primary_state;
  logic        [1:0]   secondary_state;
  logic        [1:0]   middle_state;
  logic                window_active;

  modport source (output valid, raw_x, raw_y, now_ms, primary_state, secondary_state,
                  middle_state, window_active, input ready);
  modport sink   (input valid, raw_x, raw_y, now_ms, primary_state, secondary_state,
                  middle_state, window_active, output ready);
endinterface

// qualified result word channel
interface mcmq_out_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic        [COORD_BITS-1:0] cursor_x;
  logic        [COORD_BITS-1:0] cursor_y;
  logic signed [COORD_BITS:0]   delta_x;
  logic signed [COORD_BITS:0]   delta_y;
  logic        [2:0]            left_events;
  logic        [2:0]            right_events;
  logic        [2:0]            middle_events;
  logic        [2:0]            held_mask;

  modport source (output valid, cursor_x, cursor_y, delta_x, delta_y, left_events,
                  right_events, middle_events, held_mask, input ready);
  modport sink   (input valid, cursor_x, cursor_y, delta_x, delta_y, left_events,
                  right_events, middle_events, held_mask, output ready);
endinterface

`default_nettype wire

FILE: rtl/mouse_click_and_motion_qualifier.sv
`timescale 1ns / 1ps
`default_nettype none

// Mouse click and motion qualifier.
// frame: one word per input frame (raw pointer position, ms time stamp, three
//   button states, window-active flag). result: one word per frame with the
//   clamped cursor, motion since the previous frame, down/up/double-click
//   events per logical button and the held mask.
// The APB port sets screen size, double-click window and left-handed mode;
//   write it only while no frame is in flight. pready is tied high.
// A word accepted on frame enters the input register and then the result
//   register, with all qualifying logic in between.
// Throughput: one word per cycle unless result is held off; the per-frame
//   compare and state update is one short pass, so frames flow with no gaps.
// Stall: while result is held off, the result register keeps its word, the
//   input register fills, and frame.ready drops once both are occupied.
// Reset clears both pipeline valids, the position, press times, pending first
//   clicks and held flags, and loads the register defaults (800 x 600, 500 ms,
//   right-handed).
module mouse_click_and_motion_qualifier
  import mcmq_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output      logic [APB_DW-1:0] prdata,
  output      logic              pready,
  mcmq_in_if.sink                frame,
  mcmq_out_if.source             result
);

  localparam int unsigned CLW = 17;
  localparam logic [CLW-1:0] CAP = CLW'(2 ** COORD_BITS);

  // configuration registers
  logic [SIZE_BITS-1:0]   screen_width;
  logic [SIZE_BITS-1:0]   screen_height;
  logic [WINDOW_BITS-1:0] double_click_window;
  logic                   left_handed;

  // input register
  logic                        s1_valid;
  logic signed [RAW_BITS-1:0]  s1_raw_x;
  logic signed [RAW_BITS-1:0]  s1_raw_y;
  logic [TIME_BITS-1:0]        s1_now;
  logic [1:0]                  s1_state [NUM_BTNS];
  logic                        s1_active;

  // frame-to-frame state
  logic [COORD_BITS-1:0] last_x;
  logic [COORD_BITS-1:0] last_y;
  logic [TIME_BITS-1:0]  last_press_time [NUM_BTNS];
  logic [NUM_BTNS-1:0]   pending_single;
  logic [NUM_BTNS-1:0]   held_flags;

  // next values
  logic [COORD_BITS-1:0] x_next;
  logic [COORD_BITS-1:0] y_next;
  logic signed [COORD_BITS:0] dx_next;
  logic signed [COORD_BITS:0] dy_next;
  logic [TIME_BITS-1:0]  last_press_time_next [NUM_BTNS];
  logic [NUM_BTNS-1:0]   pending_single_next;
  logic [NUM_BTNS-1:0]   held_flags_next;
  btn_ev_t               ev_logical [NUM_BTNS];

  logic o_valid;
  logic o_load;
  logic s1_fire;
  logic in_ready;

  // pipeline handshake
  assign o_load   = !o_valid || result.ready;
  assign s1_fire  = s1_valid && o_load;
  assign in_ready = !s1_valid || o_load;
  assign frame.ready  = in_ready;
  assign result.valid = o_valid;
  assign pready = 1'b1;

  // apb register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width        <= RST_SCREEN_WIDTH;
      screen_height       <= RST_SCREEN_HEIGHT;
      double_click_window <= RST_DCLICK_WINDOW;
      left_handed         <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_SCREEN_WIDTH:  screen_width        <= pwdata[SIZE_BITS-1:0];
        REG_SCREEN_HEIGHT: screen_height       <= pwdata[SIZE_BITS-1:0];
        REG_DCLICK_WINDOW: double_click_window <= pwdata[WINDOW_BITS-1:0];
        REG_LEFT_HANDED:   left_handed         <= pwdata[0];
        default: ;
      endcase
    end
  end

  // apb register readback
  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_SCREEN_WIDTH:  prdata = APB_DW'(screen_width);
      REG_SCREEN_HEIGHT: prdata = APB_DW'(screen_height);
      REG_DCLICK_WINDOW: prdata = APB_DW'(double_click_window);
      REG_LEFT_HANDED:   prdata = APB_DW'(left_handed);
      default:           prdata = '0;
    endcase
  end

  // clamp a raw coordinate into [0, min(max(size,1), 2^COORD_BITS) - 1]
  function automatic logic [COORD_BITS-1:0] clamp_coord(
    input logic signed [RAW_BITS-1:0] raw,
    input logic [SIZE_BITS-1:0]       size
  );
    logic [CLW-1:0] sz;
    logic [CLW-1:0] lim;
    logic [CLW-1:0] pos;
    sz = CLW'(size);
    if (sz == '0) sz = CLW'(1);
    if (sz > CAP) sz = CAP;
    lim = sz - CLW'(1);
    pos = CLW'(raw[RAW_BITS-2:0]);
    if (raw[RAW_BITS-1]) begin
      clamp_coord = '0;
    end else if (pos > lim) begin
      clamp_coord = lim[COORD_BITS-1:0];
    end else begin
      clamp_coord = pos[COORD_BITS-1:0];
    end
  endfunction

  // position, motion and button qualification
  always_comb begin
    logic [NUM_BTNS-1:0] pend;
    logic [TIME_BITS-1:0] elapsed;
    logic [1:0] logi;
    logic dbl;
    btn_ev_t ev;
    x_next  = clamp_coord(s1_raw_x, screen_width);
    y_next  = clamp_coord(s1_raw_y, screen_height);
    dx_next = signed'({1'b0, x_next} - {1'b0, last_x});
    dy_next = signed'({1'b0, y_next} - {1'b0, last_y});
    // any motion cancels pending first clicks
    pend = ((x_next != last_x) || (y_next != last_y)) ? '0 : pending_single;
    pending_single_next = pend;
    held_flags_next     = held_flags;
    for (int p = 0; p < NUM_BTNS; p++) begin
      last_press_time_next[p] = last_press_time[p];
      ev_logical[p] = '0;
    end
    for (int p = 0; p < NUM_BTNS; p++) begin
      if (p == BTN_MIDDLE) begin
        logi = 2'(BTN_MIDDLE);
      end else begin
        logi = 2'(p) ^ {1'b0, left_handed};
      end
      ev = '0;
      elapsed = s1_now - last_press_time[p];
      dbl = (elapsed <= TIME_BITS'(double_click_window)) && pend[p];
      case (btn_state_t'(s1_state[p]))
        BTN_PRESS: begin
          ev[EV_DOWN]   = 1'b1;
          ev[EV_DOUBLE] = dbl;
          pending_single_next[p]  = !dbl;
          held_flags_next[logi]   = 1'b1;
          last_press_time_next[p] = s1_now;
        end
        BTN_UP: begin
          if (held_flags[logi]) begin
            held_flags_next[logi] = 1'b0;
            ev[EV_UP] = 1'b1;
          end
        end
        default: ;
      endcase
      ev_logical[logi] = ev;
    end
  end

  // input register, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      o_valid        <= 1'b0;
      last_x         <= '0;
      last_y         <= '0;
      pending_single <= '0;
      held_flags     <= '0;
      for (int p = 0; p < NUM_BTNS; p++) begin
        last_press_time[p] <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid <= frame.valid;
      end
      if (o_load) begin
        o_valid <= s1_valid;
      end
      if (s1_fire) begin
        last_x         <= x_next;
        last_y         <= y_next;
        pending_single <= pending_single_next;
        held_flags     <= held_flags_next;
        for (int p = 0; p < NUM_BTNS; p++) begin
          last_press_time[p] <= last_press_time_next[p];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && frame.valid) begin
      s1_raw_x    <= frame.raw_x;
      s1_raw_y    <= frame.raw_y;
      s1_now      <= frame.now_ms;
      s1_state[BTN_LEFT]   <= frame.primary_state;
      s1_state[BTN_RIGHT]  <= frame.secondary_state;
      s1_state[BTN_MIDDLE] <= frame.middle_state;
      s1_active   <= frame.window_active;
    end
    if (s1_fire) begin
      // inactive window blanks the word but state still advances
      result.cursor_x      <= s1_active ? x_next : '0;
      result.cursor_y      <= s1_active ? y_next : '0;
      result.delta_x       <= s1_active ? dx_next : '0;
      result.delta_y       <= s1_active ? dy_next : '0;
      result.left_events   <= s1_active ? ev_logical[BTN_LEFT] : '0;
      result.right_events  <= s1_active ? ev_logical[BTN_RIGHT] : '0;
      result.middle_events <= s1_active ? ev_logical[BTN_MIDDLE] : '0;
      result.held_mask     <= s1_active ? held_flags_next : '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mcmq_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module mcmq_chk
  import mcmq_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  res_valid,
  input wire logic                  res_ready,
  input wire logic [COORD_BITS-1:0] cursor_x,
  input wire logic [2:0]            left_events,
  input wire logic [2:0]            right_events,
  input wire logic [2:0]            middle_events,
  input wire logic [2:0]            held_mask
);

  // a stalled word stays valid and keeps its cursor_x and held mask
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(cursor_x) && $stable(held_mask))
    else $error("result word changed while stalled");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // a double click is always a press, never with a release
  a_double_is_down: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!left_events[EV_DOUBLE] || left_events[EV_DOWN])
               && (!right_events[EV_DOUBLE] || right_events[EV_DOWN])
               && (!middle_events[EV_DOUBLE] || middle_events[EV_DOWN])
               && !(left_events[EV_DOWN] && left_events[EV_UP])
               && !(right_events[EV_DOWN] && right_events[EV_UP])
               && !(middle_events[EV_DOWN] && middle_events[EV_UP]))
    else $error("inconsistent button events");

  // down sets the held flag, up clears it
  a_held_tracks_events: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!left_events[EV_DOWN] || held_mask[BTN_LEFT])
               && (!left_events[EV_UP] || !held_mask[BTN_LEFT])
               && (!right_events[EV_DOWN] || held_mask[BTN_RIGHT])
               && (!right_events[EV_UP] || !held_mask[BTN_RIGHT])
               && (!middle_events[EV_DOWN] || held_mask[BTN_MIDDLE])
               && (!middle_events[EV_UP] || !held_mask[BTN_MIDDLE]))
    else $error("held mask disagrees with events");

endmodule

bind mouse_click_and_motion_qualifier mcmq_chk #(.COORD_BITS(COORD_BITS)) u_mcmq_chk (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .cursor_x      (result.cursor_x),
  .left_events   (result.left_events),
  .right_events  (result.right_events),
  .middle_events (result.middle_events),
  .held_mask     (result.held_mask)
);

`default_nettype wire
